FILE: rtl/scpr_pkg.sv
// Shared types, constants and the CRC helper of the serial command port responder.
package scpr_pkg;

    localparam int POS_W = 4;

    localparam logic [POS_W-1:0] POS_ID_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_CHECK    = 4'd3;
    localparam logic [POS_W-1:0] POS_STATUS   = 4'd4;
    localparam logic [POS_W-1:0] POS_WRAP     = 4'd5;
    localparam logic [POS_W-1:0] POS_LAST     = 4'd8;

    localparam logic [7:0] BYTE_ONES     = 8'hFF;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] REPLY_STATUS  = 8'h04;
    localparam logic [7:0] CMD_LAN       = 8'hFF;
    localparam logic [7:0] CMD_IMR       = 8'h86;
    localparam logic [7:0] CMD_ISR       = 8'h82;
    localparam logic [7:0] CRC_POLY      = 8'h1B;

    localparam logic [7:0] ID_REPLY [4] = '{8'h06, 8'h04, 8'h10, 8'h00};

    typedef struct packed {
        logic       func;
        logic       select_level;
        logic [7:0] tx_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       checksum_bad;
        logic       irq_pending;
    } rsp_t;

    typedef enum logic {
        JOB_DATA,
        JOB_STATUS
    } job_op_t;

    typedef struct packed {
        job_op_t    op;
        logic [7:0] data;
        logic       bad;
        logic       irq_set;
        logic       irq_clr;
    } job_t;

    // One byte of a CRC-8 over polynomial 0x11B, most significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (r[7]) begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/scpr_stream_if.sv
// Valid/ready channel interface that carries one request or response.
interface scpr_stream_if #(
    parameter type payload_t = logic [0:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/scpr_front.sv
// Front end: accepts requests, tracks the frame position and classifies each byte into a job.
module scpr_front (
    input  logic                clk,
    input  logic                rst_n,
    scpr_stream_if.sink         request,
    output logic                push_valid,
    output scpr_pkg::job_t      push_job,
    input  logic                push_ready
);

    logic [scpr_pkg::POS_W-1:0] pos_reg;
    logic [scpr_pkg::POS_W-1:0] pos_next;
    logic [7:0]                 cmd_reg [3];
    logic [7:0]                 crc_reg;
    logic [7:0]                 crc_next;
    logic                       fire;
    logic                       xfer;
    logic                       store;
    logic                       id_cmd;
    logic [1:0]                 id_idx;
    logic [7:0]                 b;
    scpr_pkg::job_t             job;

    assign request.ready = push_ready;
    assign fire          = request.valid && request.ready;
    assign xfer          = fire && !request.payload.func;
    assign b             = request.payload.tx_byte;
    assign store         = pos_reg < scpr_pkg::POS_CHECK;
    assign push_valid    = request.valid && !request.payload.func;
    assign push_job      = job;
    assign id_idx        = 2'(pos_reg - scpr_pkg::POS_ID_FIRST);

    always_comb
    begin
        pos_next = (pos_reg >= scpr_pkg::POS_LAST) ? scpr_pkg::POS_WRAP
                                                   : pos_reg + 4'd1;
        crc_next = scpr_pkg::crc8_byte((pos_reg == '0) ? 8'h00 : crc_reg, b);
        id_cmd   = (pos_reg >= scpr_pkg::POS_ID_FIRST) &&
                   (cmd_reg[0] == scpr_pkg::BYTE_ZERO) &&
                   (cmd_reg[1] == scpr_pkg::BYTE_ZERO);
    end

    always_comb
    begin
        job.op      = scpr_pkg::JOB_DATA;
        job.data    = scpr_pkg::BYTE_ONES;
        job.bad     = 1'b0;
        job.irq_set = 1'b0;
        job.irq_clr = 1'b0;
        if (id_cmd) begin
            job.data = scpr_pkg::ID_REPLY[id_idx];
        end else if (pos_reg == scpr_pkg::POS_CHECK) begin
            job.bad = (b != crc_reg);
        end else if (pos_reg == scpr_pkg::POS_STATUS) begin
            job.data    = scpr_pkg::REPLY_STATUS;
            job.irq_set = (cmd_reg[0] == scpr_pkg::CMD_LAN) &&
                          (cmd_reg[1] == scpr_pkg::BYTE_ZERO) &&
                          (cmd_reg[2] == scpr_pkg::BYTE_ZERO);
            job.irq_clr = (cmd_reg[0] == scpr_pkg::CMD_ISR);
        end else if (pos_reg > scpr_pkg::POS_STATUS) begin
            unique case (cmd_reg[0])
                scpr_pkg::CMD_LAN: job.data = scpr_pkg::BYTE_ONES;
                scpr_pkg::CMD_IMR: job.data = scpr_pkg::BYTE_ZERO;
                scpr_pkg::CMD_ISR: job.op   = scpr_pkg::JOB_STATUS;
                default:           job.data = b;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
        end else if (xfer) begin
            pos_reg <= pos_next;
        end else if (fire && request.payload.select_level) begin
            pos_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer && store) begin
            cmd_reg[pos_reg[1:0]] <= b;
            crc_reg               <= crc_next;
        end
    end

endmodule

FILE: rtl/scpr_queue.sv
// Short job queue that decouples the front end from the back end.
module scpr_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  scpr_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output scpr_pkg::job_t pop_job
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    scpr_pkg::job_t   slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_reg;
    logic [IDX_W-1:0] rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == IDX_LAST) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == IDX_LAST) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/scpr_back.sv
// Back end: carries out jobs, keeps the interrupt flag and registers the response.
module scpr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  scpr_pkg::job_t pop_job,
    scpr_stream_if.source  response
);

    logic           out_valid_reg;
    scpr_pkg::rsp_t out_reg;
    scpr_pkg::rsp_t out_next;
    logic           irq_reg;
    logic           irq_next;
    logic           load;

    assign pop_ready        = !out_valid_reg || response.ready;
    assign load             = pop_valid && pop_ready;
    assign response.valid   = out_valid_reg;
    assign response.payload = out_reg;

    always_comb
    begin
        irq_next = irq_reg;
        if (pop_job.irq_set) begin
            irq_next = 1'b1;
        end else if (pop_job.irq_clr) begin
            irq_next = 1'b0;
        end
        out_next.rx_byte      = pop_job.data;
        out_next.checksum_bad = pop_job.bad;
        out_next.irq_pending  = irq_next;
        if (pop_job.op == scpr_pkg::JOB_STATUS) begin
            out_next.rx_byte = irq_reg ? scpr_pkg::BYTE_ONES : scpr_pkg::BYTE_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            irq_reg       <= 1'b0;
        end else begin
            if (pop_ready) begin
                out_valid_reg <= pop_valid;
            end
            if (load) begin
                irq_reg <= irq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: rtl/serial_command_port_responder.sv
// Top level of the serial command port responder.
// The block takes one request per clock cycle while the queue has room and returns one
// response for every byte transfer; a chip-select request gives no response. The front end
// decodes the byte against the frame position and writes the job into a short queue at the
// edge that accepts the request, and the back end moves it into the output register once
// that register is free. The queue lets requests keep flowing while a response waits.
module serial_command_port_responder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    scpr_stream_if.sink   request,
    scpr_stream_if.source response
);

    logic           push_valid;
    logic           push_ready;
    scpr_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    scpr_pkg::job_t pop_job;

    scpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    scpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    scpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .response  (response)
    );

endmodule

FILE: rtl/scpr_checker.sv
// Port-level checks on the response channel of the serial command port responder.
module scpr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_rx_byte,
    input logic       rsp_checksum_bad,
    input logic       rsp_irq_pending
);

    logic last_irq_reg;
    logic rsp_fire;

    assign rsp_fire = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_irq_reg <= 1'b0;
        end else if (rsp_fire) begin
            last_irq_reg <= rsp_irq_pending;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_rx_byte) && $stable(rsp_checksum_bad) && $stable(rsp_irq_pending))
        else $error("response payload changed while stalled");

    a_bad_check_reply: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_checksum_bad |-> rsp_rx_byte == 8'hFF)
        else $error("checksum failure on a byte other than the check byte");

    a_irq_change_reply: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && (rsp_irq_pending != last_irq_reg) |-> rsp_rx_byte == 8'h04)
        else $error("interrupt flag changed outside the status byte");

endmodule

bind serial_command_port_responder scpr_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (response.valid),
    .rsp_ready        (response.ready),
    .rsp_rx_byte      (response.payload.rx_byte),
    .rsp_checksum_bad (response.payload.checksum_bad),
    .rsp_irq_pending  (response.payload.irq_pending)
);
